>>> rtl/core/rbnh_pkg.sv
package rbnh_pkg;

    // Field widths of the stream items.
    localparam int CMD_W   = 1;
    localparam int SLOT_W  = 6;
    localparam int KIND_W  = 2;
    localparam int COORD_W = 32;
    localparam int SCALE_W = 31;
    localparam int DIR_W   = 18;
    localparam int THR_W   = 16;
    localparam int DIST_W  = 31;

    // A box bound minus a ray origin always fits in this many signed bits.
    localparam int DIFF_W  = 34;
    localparam int T_W     = 32;

    localparam logic [CMD_W-1:0]  CMD_LOAD  = 1'b0;
    localparam logic [CMD_W-1:0]  CMD_QUERY = 1'b1;

    localparam logic [KIND_W-1:0] KIND_EMPTY = 2'd0;
    localparam logic [KIND_W-1:0] KIND_MESH  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CAM   = 2'd2;

    localparam logic signed [T_W-1:0] T_MIN = 32'sh8000_0000;
    localparam logic signed [T_W-1:0] T_MAX = 32'sh7FFF_FFFF;

    // One slab division: (bound - origin) * 2^FRAC_BITS / dir.
    typedef struct packed {
        logic signed [DIFF_W-1:0] num;
        logic signed [DIR_W-1:0]  den;
    } div_req_t;

endpackage

>>> rtl/core/rbnh_ram.sv
module rbnh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic                                  re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/core/rbnh_div.sv
module rbnh_div
    import rbnh_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  div_req_t              req,
    output logic                  busy,
    output logic                  done,
    output logic signed [T_W-1:0] quo
);

    localparam int NW  = DIFF_W + FRAC_BITS;
    localparam int DMW = DIR_W;

    typedef enum logic [2:0] {
        D_IDLE = 3'b001,
        D_RUN  = 3'b010,
        D_SAT  = 3'b100
    } dstate_t;

    dstate_t               state_reg, state_next;
    logic [DMW-1:0]        rem_reg, rem_next;
    logic [T_W-1:0]        q_reg, q_next;
    logic [DMW-1:0]        dmag_reg, dmag_next;
    logic                  neg_reg, neg_next;
    logic [4:0]            cnt_reg, cnt_next;
    logic                  done_reg, done_next;
    logic signed [T_W-1:0] res_reg, res_next;

    logic [DIFF_W-1:0]     num_abs;
    logic [NW-1:0]         nmag;
    logic [NW-33:0]        upper;
    logic [DMW-1:0]        den_abs;
    logic [DMW:0]          trial;
    logic [DMW:0]          trial_sub;
    logic                  ge;

    always_comb
    begin
        num_abs   = req.num[DIFF_W-1] ? DIFF_W'(-req.num) : DIFF_W'(req.num);
        den_abs   = req.den[DIR_W-1] ? DMW'(-req.den) : DMW'(req.den);
        nmag      = {num_abs, {FRAC_BITS{1'b0}}};
        upper     = nmag[NW-1:32];
        trial     = {rem_reg, q_reg[T_W-1]};
        trial_sub = trial - {1'b0, dmag_reg};
        ge        = trial >= {1'b0, dmag_reg};

        state_next = state_reg;
        rem_next   = rem_reg;
        q_next     = q_reg;
        dmag_next  = dmag_reg;
        neg_next   = neg_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        res_next   = res_reg;

        case (state_reg)
            D_IDLE:
            begin
                if (start)
                begin
                    neg_next  = req.num[DIFF_W-1] ^ req.den[DIR_W-1];
                    dmag_next = den_abs;
                    if (num_abs == '0)
                    begin
                        res_next  = '0;
                        done_next = 1'b1;
                    end
                    else if (32'(upper) >= 32'(den_abs))
                    begin
                        // Quotient needs more than 32 bits: saturate at once.
                        res_next  = (req.num[DIFF_W-1] ^ req.den[DIR_W-1]) ? T_MIN : T_MAX;
                        done_next = 1'b1;
                    end
                    else
                    begin
                        rem_next   = DMW'(upper);
                        q_next     = nmag[T_W-1:0];
                        cnt_next   = '0;
                        state_next = D_RUN;
                    end
                end
            end
            D_RUN:
            begin
                rem_next = ge ? trial_sub[DMW-1:0] : trial[DMW-1:0];
                q_next   = {q_reg[T_W-2:0], ge};
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd31)
                begin
                    state_next = D_SAT;
                end
            end
            D_SAT:
            begin
                if (neg_reg)
                begin
                    res_next = q_reg[T_W-1] ? T_MIN : T_W'(-q_reg);
                end
                else
                begin
                    res_next = q_reg[T_W-1] ? T_MAX : T_W'(q_reg);
                end
                done_next  = 1'b1;
                state_next = D_IDLE;
            end
            default:
            begin
                state_next = D_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        q_reg    <= q_next;
        dmag_reg <= dmag_next;
        neg_reg  <= neg_next;
        cnt_reg  <= cnt_next;
        res_reg  <= res_next;
    end

    assign busy = state_reg != D_IDLE;
    assign done = done_reg;
    assign quo  = res_reg;

endmodule

>>> rtl/core/ray_box_nearest_hit.sv
// Ray picking against a table of axis-aligned boxes.
// Input stream (s_axis_*): tuser carries the command. A load item writes one
// table slot with a box kind, centre and size and gives no result. A query item
// carries a ray origin and direction; the block runs a slab test on every filled
// slot and returns one result item on the output stream (m_axis_*): tuser is the
// hit flag, tdata the nearest slot and entry distance.
// A query walks the table slot by slot. Each axis of a filled slot that is not
// parallel to the ray takes two slab divisions; an axis within the threshold
// needs none. A division that saturates or has a zero numerator finishes without
// the bit-by-bit run. The single shared divider produces one quotient bit per
// cycle, and the walk waits for each quotient before it goes on.
// While a query runs s_axis_tready is low.
// The parallel threshold register is written through cfg_wr_en / cfg_wr_data.
// Reset empties every slot and sets the threshold to one fixed-point step.
// A finished result waits in the output register; if the receiver stalls,
// loads are still taken, and a later query holds its result until the slot in
// the output register is free.
module ray_box_nearest_hit
    import rbnh_pkg::*;
#(
    parameter int MAX_BOXES = 64,
    parameter int FRAC_BITS = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    // tdata from bit 0: slot, kind, point_x, point_y, point_z,
    // scale_x, scale_y, scale_z, dir_x, dir_y, dir_z, zero pad.
    input  logic [255:0]     s_axis_tdata,
    // tuser: cmd.
    input  logic             s_axis_tuser,
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    // tdata from bit 0: hit_slot, hit_distance, zero pad.
    output logic [39:0]      m_axis_tdata,
    // tuser: hit.
    output logic             m_axis_tuser,
    input  logic             cfg_wr_en,
    input  logic [THR_W-1:0] cfg_wr_data
);

    localparam int AW    = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
    localparam int RAM_W = 3 * COORD_W + 3 * SCALE_W;
    localparam logic [SCALE_W-1:0] CAM_HALF = SCALE_W'(((3 << FRAC_BITS) + 5) / 10);

    typedef enum logic [10:0] {
        S_IDLE = 11'b000_0000_0001,
        S_RD   = 11'b000_0000_0010,
        S_BND  = 11'b000_0000_0100,
        S_AXIS = 11'b000_0000_1000,
        S_DIV1 = 11'b000_0001_0000,
        S_DIV2 = 11'b000_0010_0000,
        S_UPD  = 11'b000_0100_0000,
        S_CHK  = 11'b000_1000_0000,
        S_CAND = 11'b001_0000_0000,
        S_ADV  = 11'b010_0000_0000,
        S_FIN  = 11'b100_0000_0000
    } state_t;

    // Input fields.
    logic [SLOT_W-1:0]         in_slot;
    logic [KIND_W-1:0]         in_kind;
    logic signed [COORD_W-1:0] in_point [3];
    logic [SCALE_W-1:0]        in_scale [3];
    logic signed [DIR_W-1:0]   in_dir [3];

    assign in_slot     = s_axis_tdata[5:0];
    assign in_kind     = s_axis_tdata[7:6];
    assign in_point[0] = s_axis_tdata[39:8];
    assign in_point[1] = s_axis_tdata[71:40];
    assign in_point[2] = s_axis_tdata[103:72];
    assign in_scale[0] = s_axis_tdata[134:104];
    assign in_scale[1] = s_axis_tdata[165:135];
    assign in_scale[2] = s_axis_tdata[196:166];
    assign in_dir[0]   = s_axis_tdata[214:197];
    assign in_dir[1]   = s_axis_tdata[232:215];
    assign in_dir[2]   = s_axis_tdata[250:233];

    // Control state.
    state_t                    state_reg, state_next;
    logic [MAX_BOXES-1:0]      active_reg, active_next;
    logic [THR_W-1:0]          thr_reg, thr_next;
    logic                      m_valid_reg, m_valid_next;

    // Query datapath.
    logic signed [COORD_W-1:0] org_reg [3];
    logic signed [COORD_W-1:0] org_next [3];
    logic signed [DIR_W-1:0]   dir_reg [3];
    logic signed [DIR_W-1:0]   dir_next [3];
    logic [AW-1:0]             slot_reg, slot_next;
    logic [1:0]                ax_reg, ax_next;
    logic signed [DIFF_W-1:0]  lo_reg, lo_next, hi_reg, hi_next;
    logic signed [T_W-1:0]     tmin_reg, tmin_next, tmax_reg, tmax_next;
    logic signed [T_W-1:0]     t1_reg, t1_next, t2_reg, t2_next;
    logic signed [T_W-1:0]     best_reg, best_next;
    logic [AW-1:0]             best_slot_reg, best_slot_next;
    logic                      found_reg, found_next;
    logic                      out_hit_reg, out_hit_next;
    logic [SLOT_W-1:0]         out_slot_reg, out_slot_next;
    logic [DIST_W-1:0]         out_dist_reg, out_dist_next;

    // Table memory.
    logic                      ram_we, ram_re;
    logic [AW-1:0]             ram_waddr;
    logic [RAM_W-1:0]          ram_wdata, ram_rdata;

    // Shared divider.
    logic                      div_start, div_busy, div_done;
    div_req_t                  div_req;
    logic signed [T_W-1:0]     div_quo;

    logic                      in_acc;
    logic [SCALE_W-1:0]        half_in [3];
    logic signed [COORD_W-1:0] cen_sel;
    logic [SCALE_W-1:0]        half_sel;
    logic signed [COORD_W-1:0] org_sel;
    logic signed [DIR_W-1:0]   dir_sel;
    logic signed [DIFF_W-1:0]  org_ext;
    logic [DIR_W-1:0]          dmag;
    logic                      parallel;
    logic signed [T_W-1:0]     near_t, far_t;

    rbnh_ram #(
        .WIDTH (RAM_W),
        .DEPTH (MAX_BOXES)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (slot_reg),
        .rdata (ram_rdata)
    );

    rbnh_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .req   (div_req),
        .busy  (div_busy),
        .done  (div_done),
        .quo   (div_quo)
    );

    assign s_axis_tready = state_reg == S_IDLE;
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    // A load writes centre and half extent; only mesh and camera slots are
    // marked active, so a slot loaded as empty or with the unused kind is skipped.
    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            half_in[a] = (in_kind == KIND_CAM) ? CAM_HALF : (in_scale[a] >> 1);
        end
        ram_wdata = {half_in[2], half_in[1], half_in[0],
                     in_point[2], in_point[1], in_point[0]};
        ram_waddr = AW'(in_slot);
        ram_we    = in_acc && (s_axis_tuser == CMD_LOAD) && (32'(in_slot) < MAX_BOXES);
    end

    // Per-axis selection of the slot in the read register and of the ray.
    always_comb
    begin
        case (ax_reg)
            2'd0:
            begin
                cen_sel  = ram_rdata[31:0];
                half_sel = ram_rdata[126:96];
                org_sel  = org_reg[0];
                dir_sel  = dir_reg[0];
            end
            2'd1:
            begin
                cen_sel  = ram_rdata[63:32];
                half_sel = ram_rdata[157:127];
                org_sel  = org_reg[1];
                dir_sel  = dir_reg[1];
            end
            default:
            begin
                cen_sel  = ram_rdata[95:64];
                half_sel = ram_rdata[188:158];
                org_sel  = org_reg[2];
                dir_sel  = dir_reg[2];
            end
        endcase
        org_ext  = DIFF_W'(org_sel);
        dmag     = dir_sel[DIR_W-1] ? DIR_W'(-dir_sel) : DIR_W'(dir_sel);
        parallel = (dir_sel == '0) || (dmag < DIR_W'(thr_reg));
        near_t   = (t1_reg > t2_reg) ? t2_reg : t1_reg;
        far_t    = (t1_reg > t2_reg) ? t1_reg : t2_reg;
    end

    always_comb
    begin
        state_next     = state_reg;
        active_next    = active_reg;
        thr_next       = cfg_wr_en ? cfg_wr_data : thr_reg;
        m_valid_next   = m_valid_reg && !m_axis_tready;
        org_next       = org_reg;
        dir_next       = dir_reg;
        slot_next      = slot_reg;
        ax_next        = ax_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        tmin_next      = tmin_reg;
        tmax_next      = tmax_reg;
        t1_next        = t1_reg;
        t2_next        = t2_reg;
        best_next      = best_reg;
        best_slot_next = best_slot_reg;
        found_next     = found_reg;
        out_hit_next   = out_hit_reg;
        out_slot_next  = out_slot_reg;
        out_dist_next  = out_dist_reg;
        ram_re         = 1'b0;
        div_start      = 1'b0;
        div_req.num    = lo_reg - org_ext;
        div_req.den    = dir_sel;

        if (ram_we)
        begin
            active_next[ram_waddr] = in_kind inside {KIND_MESH, KIND_CAM};
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_acc && (s_axis_tuser == CMD_QUERY))
                begin
                    for (int a = 0; a < 3; a++)
                    begin
                        org_next[a] = in_point[a];
                        dir_next[a] = in_dir[a];
                    end
                    slot_next      = '0;
                    found_next     = 1'b0;
                    best_next      = '0;
                    best_slot_next = '0;
                    state_next     = S_RD;
                end
            end
            S_RD:
            begin
                if (active_reg[slot_reg])
                begin
                    ram_re     = 1'b1;
                    ax_next    = 2'd0;
                    tmin_next  = T_MIN;
                    tmax_next  = T_MAX;
                    state_next = S_BND;
                end
                else
                begin
                    state_next = S_ADV;
                end
            end
            S_BND:
            begin
                lo_next    = DIFF_W'(cen_sel) - DIFF_W'(half_sel);
                hi_next    = DIFF_W'(cen_sel) + DIFF_W'(half_sel);
                state_next = S_AXIS;
            end
            S_AXIS:
            begin
                if (parallel)
                begin
                    if ((org_ext < lo_reg) || (org_ext > hi_reg))
                    begin
                        state_next = S_ADV;
                    end
                    else if (ax_reg == 2'd2)
                    begin
                        state_next = S_CAND;
                    end
                    else
                    begin
                        ax_next    = ax_reg + 2'd1;
                        state_next = S_BND;
                    end
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = S_DIV1;
                end
            end
            S_DIV1:
            begin
                div_req.num = hi_reg - org_ext;
                if (div_done)
                begin
                    t1_next    = div_quo;
                    div_start  = 1'b1;
                    state_next = S_DIV2;
                end
            end
            S_DIV2:
            begin
                if (div_done)
                begin
                    t2_next    = div_quo;
                    state_next = S_UPD;
                end
            end
            S_UPD:
            begin
                tmin_next  = (near_t > tmin_reg) ? near_t : tmin_reg;
                tmax_next  = (far_t < tmax_reg) ? far_t : tmax_reg;
                state_next = S_CHK;
            end
            S_CHK:
            begin
                if (tmin_reg > tmax_reg)
                begin
                    state_next = S_ADV;
                end
                else if (ax_reg == 2'd2)
                begin
                    state_next = S_CAND;
                end
                else
                begin
                    ax_next    = ax_reg + 2'd1;
                    state_next = S_BND;
                end
            end
            S_CAND:
            begin
                // Strictly nearer only, so the lowest slot wins a tie.
                if ((tmin_reg > 0) && (!found_reg || (tmin_reg < best_reg)))
                begin
                    found_next     = 1'b1;
                    best_next      = tmin_reg;
                    best_slot_next = slot_reg;
                end
                state_next = S_ADV;
            end
            S_ADV:
            begin
                if (slot_reg == AW'(MAX_BOXES - 1))
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    slot_next  = slot_reg + 1'b1;
                    state_next = S_RD;
                end
            end
            S_FIN:
            begin
                if (!m_valid_reg || m_axis_tready)
                begin
                    m_valid_next  = 1'b1;
                    out_hit_next  = found_reg;
                    out_slot_next = found_reg ? SLOT_W'(best_slot_reg) : '0;
                    out_dist_next = found_reg ? best_reg[DIST_W-1:0] : '0;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            active_reg  <= '0;
            thr_reg     <= THR_W'(1);
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            active_reg  <= active_next;
            thr_reg     <= thr_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        org_reg       <= org_next;
        dir_reg       <= dir_next;
        slot_reg      <= slot_next;
        ax_reg        <= ax_next;
        lo_reg        <= lo_next;
        hi_reg        <= hi_next;
        tmin_reg      <= tmin_next;
        tmax_reg      <= tmax_next;
        t1_reg        <= t1_next;
        t2_reg        <= t2_next;
        best_reg      <= best_next;
        best_slot_reg <= best_slot_next;
        found_reg     <= found_next;
        out_hit_reg   <= out_hit_next;
        out_slot_reg  <= out_slot_next;
        out_dist_reg  <= out_dist_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tuser  = out_hit_reg;
    assign m_axis_tdata  = {3'b000, out_dist_reg, out_slot_reg};

    // The divider only runs on behalf of a slab test.
    a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !div_busy)
        else $error("divider busy while the block is idle");

    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> ((state_reg == S_DIV1) || (state_reg == S_DIV2)))
        else $error("divider finished outside a division wait");

    a_query_walk: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && (s_axis_tuser == CMD_QUERY))
        |=> (state_reg == S_RD))
        else $error("query item did not start the table walk");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == '0))
        else $error("no-hit result carries a slot or distance");

    a_hit_ahead: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (out_dist_reg != '0))
        else $error("hit result with a zero entry distance");

endmodule
